/* hw/rtl/dalu_pkg.sv */
package dalu_pkg;

  // Operation codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_SHL = 3'd2,
    OP_SHR = 3'd3,
    OP_TST = 3'd4
  } op_t;

  // Scaling modes: where E and U are judged
  localparam logic [1:0] SCALE_NONE = 2'd0;
  localparam logic [1:0] SCALE_DOWN = 2'd1;
  localparam logic [1:0] SCALE_UP   = 2'd2;

  // Register select: paddr[2] picks the register
  localparam logic REG_SCALING = 1'b0;
  localparam logic REG_ARITH40 = 1'b1;

  localparam int DataW = 56;

  // Condition flags
  typedef struct packed {
    logic l;
    logic e;
    logic u;
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

endpackage

/* hw/rtl/dalu_core.sv */
// Single-pass ALU: adder, barrel shifter and flag logic.
module dalu_core (
  input  logic [2:0]                     op,
  input  logic [dalu_pkg::DataW-1:0]     a,
  input  logic [dalu_pkg::DataW-1:0]     b,
  input  logic [5:0]                     n,
  input  logic [1:0]                     scaling_mode,
  input  logic                           arith_40bit_mode,
  input  dalu_pkg::flags_t               flags_in,
  output logic [dalu_pkg::DataW-1:0]     res,
  output dalu_pkg::flags_t               flags_out
);

  logic [56:0] sum;
  logic [56:0] diff;
  logic [55:0] shl_pre;
  logic [55:0] shl_res;
  logic [55:0] shl_mask;
  logic [55:0] shl_top;
  logic        shl_v;
  logic [5:0]  n_m1;
  logic [63:0] shr_x;
  logic [63:0] shr_pre;
  logic [55:0] shr_res;
  logic [55:0] judge_val;
  logic        j_e;
  logic        j_u;

  assign n_m1 = (n == 6'd0) ? 6'd0 : n - 6'd1;

  // Add and subtract with carry/borrow out
  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, b} - {1'b0, a};

  // Shift left in two steps: by n-1, then one more; the bit leaving is carry
  assign shl_pre  = b << n_m1;
  assign shl_res  = (n == 6'd0) ? b : {shl_pre[54:0], 1'b0};
  assign shl_mask = (n >= 6'd56) ? '1 : ({56{1'b1}} << (6'd55 - n));
  assign shl_top  = b & shl_mask;
  // Shifting the whole word out overflows on any nonzero value
  assign shl_v    = (n >= 6'd56) ? (b != '0) :
                    ((shl_top != '0) && (shl_top != shl_mask));

  // Shift right: sign extend from bit 39 or 55, then arithmetic shift
  assign shr_x   = arith_40bit_mode ? {{24{b[39]}}, b[39:0]} : {{8{b[55]}}, b};
  assign shr_pre = $unsigned($signed(shr_x) >>> n_m1);
  assign shr_res = (n == 6'd0) ? shr_x[55:0] : shr_pre[56:1];

  // Value judged for E, U, N, Z
  always_comb begin
    case (op)
      dalu_pkg::OP_ADD: judge_val = sum[55:0];
      dalu_pkg::OP_SUB: judge_val = diff[55:0];
      dalu_pkg::OP_SHL: judge_val = shl_res;
      default:          judge_val = b;
    endcase
  end

  // Extension and unnormalized per scaling mode
  always_comb begin
    unique case (scaling_mode)
      dalu_pkg::SCALE_NONE: begin
        j_e = (|judge_val[55:47]) && !(&judge_val[55:47]);
        j_u = judge_val[47] == judge_val[46];
      end
      dalu_pkg::SCALE_DOWN: begin
        j_e = (|judge_val[55:48]) && !(&judge_val[55:48]);
        j_u = judge_val[48] == judge_val[47];
      end
      dalu_pkg::SCALE_UP: begin
        j_e = (|judge_val[55:46]) && !(&judge_val[55:46]);
        j_u = judge_val[46] == judge_val[45];
      end
      default: begin
        j_e = 1'b0;
        j_u = 1'b0;
      end
    endcase
  end

  // Result and flag update per operation
  always_comb begin
    flags_out = flags_in;
    res       = '0;
    case (op) inside
      dalu_pkg::OP_ADD, dalu_pkg::OP_SUB, dalu_pkg::OP_SHL, dalu_pkg::OP_TST: begin
        flags_out.e = j_e;
        flags_out.u = j_u;
        flags_out.n = judge_val[55];
        flags_out.z = (judge_val == '0);
        flags_out.v = 1'b0;
        res         = judge_val;
        case (op)
          dalu_pkg::OP_ADD: begin
            flags_out.v = ~(a[55] ^ b[55]) & (a[55] ^ sum[55]);
            flags_out.c = sum[56];
          end
          dalu_pkg::OP_SUB: begin
            flags_out.v = (a[55] ^ b[55]) & (b[55] ^ diff[55]);
            flags_out.c = diff[56];
          end
          dalu_pkg::OP_SHL: begin
            flags_out.v = shl_v;
            flags_out.c = (n != 6'd0) && shl_pre[55];
          end
          default: ;
        endcase
        flags_out.l = flags_in.l | flags_out.v;
      end
      dalu_pkg::OP_SHR: begin
        flags_out.v = 1'b0;
        flags_out.c = (n != 6'd0) && shr_pre[0];
        res         = shr_res;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/dsp_accumulator_alu_56bit_core.sv */
// Path: an accepted input word passes the input register, then the result
// register around one adder/shifter pass, to become its result word.
// Throughput: one word per cycle unless out_ready stalls; flags update as
// each word moves into the result register, so they follow word order.
// Reset (rst, synchronous): flags, config registers and valids clear to 0.
module dsp_accumulator_alu_56bit_core (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [55:0] operand_a,
  input  logic [55:0] operand_b,
  input  logic [5:0]  shift_count,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [55:0] result,
  output logic        flag_e,
  output logic        flag_u,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_v,
  output logic        flag_c,
  output logic        flag_l
);

  logic             scaling_mode;
  logic [1:0]       scaling_q;
  logic             arith40_q;
  logic             cfg_wr;
  logic             in_q_valid;
  logic [2:0]       op_q;
  logic [55:0]      a_q;
  logic [55:0]      b_q;
  logic [5:0]       n_q;
  logic             move;
  logic [55:0]      res_next;
  dalu_pkg::flags_t flags;
  dalu_pkg::flags_t flags_next;

  assign scaling_mode = paddr[2];

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaling_q <= '0;
      arith40_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (scaling_mode)
        dalu_pkg::REG_SCALING: scaling_q <= pwdata[1:0];
        dalu_pkg::REG_ARITH40: arith40_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (scaling_mode)
      dalu_pkg::REG_SCALING: prdata = {30'd0, scaling_q};
      dalu_pkg::REG_ARITH40: prdata = {31'd0, arith40_q};
      default:               prdata = '0;
    endcase
  end

  // Handshake: input stage advances whenever the result slot is free
  assign move     = in_q_valid & (~out_valid | out_ready);
  assign in_ready = ~in_q_valid | move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_q <= opcode;
      a_q  <= operand_a;
      b_q  <= operand_b;
      n_q  <= shift_count;
    end
  end

  dalu_core u_core (
    .op               (op_q),
    .a                (a_q),
    .b                (b_q),
    .n                (n_q),
    .scaling_mode     (scaling_q),
    .arith_40bit_mode (arith40_q),
    .flags_in         (flags),
    .res              (res_next),
    .flags_out        (flags_next)
  );

  // Result register and flag state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
        flags     <= flags_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result <= res_next;
    end
  end

  assign flag_e = flags.e;
  assign flag_u = flags.u;
  assign flag_n = flags.n;
  assign flag_z = flags.z;
  assign flag_v = flags.v;
  assign flag_c = flags.c;
  assign flag_l = flags.l;

  // Limit flag is sticky
  a_l_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.l |=> flags.l)
    else $error("limit flag cleared");

  // Overflow always comes with limit
  a_v_sets_l: assert property (@(posedge clk) disable iff (rst)
    flags.v |-> flags.l)
    else $error("overflow without limit");

  // Input stalls only when both stages are full and output is blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_q_valid && out_valid && !out_ready))
    else $error("input stalled without cause");

  // A word moving forward shows up as a result
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("moved word lost");

  // Shift right leaves E, U, N, Z untouched
  a_shr_keep: assert property (@(posedge clk) disable iff (rst)
    (move && op_q == dalu_pkg::OP_SHR) |=>
      (flags.e == $past(flags.e) && flags.u == $past(flags.u) &&
       flags.n == $past(flags.n) && flags.z == $past(flags.z)))
    else $error("shift right changed E/U/N/Z");

endmodule
